// ----- sv/single_phase_dq_current_regulator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle-implication property wrappers,
// clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_PHASE_DQ_CURRENT_REGULATOR_ASSERT_SVH
`define SINGLE_PHASE_DQ_CURRENT_REGULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SPDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spdq assertion failed");
`define SPDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spdq assertion failed");
`else
`define SPDQ_ASSERT_NOW(label, ante, cons)
`define SPDQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/spdq_pkg.sv -----
// ----------------------------------------------------------------------------
// spdq_pkg
// Types, constants and the sine table shared by the dq current regulator.
// ----------------------------------------------------------------------------
package spdq_pkg;

  localparam int DELAY_DEPTH  = 128;
  localparam int SAMPLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(DELAY_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int REF_W     = 17;
  localparam int INT_W     = 24;
  localparam int SIN_W     = 17;
  localparam int ROOT_W    = 15;
  localparam int HI_SH     = 18;

  localparam int ID_W  = SAMPLE_WIDTH + 2;
  localparam int ERR_W = ((ID_W > REF_W) ? ID_W : REF_W) + 1;
  localparam int V_W   = ERR_W + HI_SH;
  localparam int MA_W  = (ERR_W > HI_SH + 1) ? ERR_W : HI_SH + 1;
  localparam int MB_W  = 17;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = P_W + HI_SH + 2;

  localparam int COSPHI_LO = 16384;
  localparam int COSPHI_HI = 32768;
  localparam int INTEG_LIM = 1048576;
  localparam int DUTY_LO   = 3277;
  localparam int DUTY_HI   = 62259;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_TYPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_AMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_PROP_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_INTEG_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PROP_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INTEG_GAIN = 3'd6;

  localparam logic [1:0] LOAD_INDUCTIVE  = 2'd1;
  localparam logic [1:0] LOAD_CAPACITIVE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FETCH, ST_COS,
    ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6, ST_X7,
    ST_X8, ST_X9, ST_X10, ST_X11, ST_X12, ST_X13, ST_X14,
    ST_OUT,
    ST_RCC, ST_RV, ST_RSM, ST_RSC, ST_RD, ST_RQ, ST_RF
  } state_t;

  typedef enum logic [3:0] {
    A_IA, A_IB, A_ED, A_EQ, A_VDH, A_VDL, A_VQH, A_VQL, A_CCL, A_TRIAL, A_AMP
  } a_sel_t;

  typedef enum logic [3:0] {
    B_C, B_S, B_KID, B_KIQ, B_KPD, B_KPQ, B_CCL, B_TRIAL, B_ROOT
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LOAD_HI, ACC_SUB_HI
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    capture;
    logic    cfg_we;
    logic    fetch;
    logic    cos_ld;
    logic    id_ld;
    logic    ed_ld;
    logic    eq_ld;
    logic    dint_ld;
    logic    qint_ld;
    logic    vd_ld;
    logic    vq_ld;
    logic    duty_ld;
    logic    sq_init;
    logic    sq_cmp;
    logic    dref_ld;
    logic    qref_ld;
  } cmd_t;

  localparam logic [15:0] QSIN_TAB [65] = '{
    16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
    16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039,
    16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447,
    16'd16151, 16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520,
    16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595, 16'd23170,
    16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26319,
    16'd26790, 16'd27245, 16'd27684, 16'd28106, 16'd28511, 16'd28898,
    16'd29269, 16'd29622, 16'd29957, 16'd30273, 16'd30572, 16'd30852,
    16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138,
    16'd32285, 16'd32413, 16'd32521, 16'd32610, 16'd32679, 16'd32729,
    16'd32758, 16'd32768
  };

  // Q1.15 sine of a 16-bit phase, interpolated on the low 8 bits
  function automatic logic signed [SIN_W-1:0] sin_q15(input logic [15:0] ph);
    logic [14:0] x;
    logic [6:0]  i;
    logic [7:0]  f;
    logic [15:0] base;
    logic [9:0]  diff;
    logic [17:0] prod;
    logic [15:0] mag;
    x = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    i = x[14:8];
    f = x[7:0];
    if (i >= 7'd64) begin
      mag = QSIN_TAB[64];
    end else begin
      base = QSIN_TAB[i[5:0]];
      diff = 10'(QSIN_TAB[7'(i + 7'd1)] - base);
      prod = 18'(diff * f) + 18'd128;
      mag  = base + 16'(prod[17:8]);
    end
    sin_q15 = ph[15] ? -SIN_W'(signed'({1'b0, mag})) : SIN_W'(signed'({1'b0, mag}));
  endfunction

endpackage

// ----- sv/spdq_ram.sv -----
// ----------------------------------------------------------------------------
// spdq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spdq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/spdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spdq_ctrl
// Sequencer: item steps, reference recompute and output register valid.
// ----------------------------------------------------------------------------
`include "single_phase_dq_current_regulator_assert.svh"

module spdq_ctrl
  import spdq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  output logic                 cfg_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 sq_last,
  output cmd_t                 cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   ref_write;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;
  assign ref_write = (cfg_index == REG_LOAD_TYPE) || (cfg_index == REG_POWER_FACTOR) ||
                     (cfg_index == REG_CURRENT_AMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.a_sel     = A_IA;
    cmd.b_sel     = B_C;
    cmd.acc_op    = ACC_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (ref_write) begin
            state_nxt = ST_RCC;
          end
        end else if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_COS;
      end
      ST_COS: begin
        cmd.cos_ld = 1'b1;
        state_nxt  = ST_X1;
      end
      ST_X1: begin
        cmd.a_sel = A_IA; cmd.b_sel = B_C;
        state_nxt = ST_X2;
      end
      ST_X2: begin
        cmd.a_sel = A_IB; cmd.b_sel = B_S; cmd.acc_op = ACC_LOAD;
        state_nxt = ST_X3;
      end
      ST_X3: begin
        cmd.a_sel = A_IB; cmd.b_sel = B_C; cmd.acc_op = ACC_ADD;
        state_nxt = ST_X4;
      end
      ST_X4: begin
        cmd.a_sel = A_IA; cmd.b_sel = B_S; cmd.acc_op = ACC_LOAD;
        cmd.id_ld = 1'b1;
        state_nxt = ST_X5;
      end
      ST_X5: begin
        cmd.acc_op = ACC_SUB; cmd.ed_ld = 1'b1;
        state_nxt  = ST_X6;
      end
      ST_X6: begin
        cmd.a_sel = A_ED; cmd.b_sel = B_KID; cmd.eq_ld = 1'b1;
        state_nxt = ST_X7;
      end
      ST_X7: begin
        cmd.a_sel = A_EQ; cmd.b_sel = B_KIQ; cmd.dint_ld = 1'b1;
        state_nxt = ST_X8;
      end
      ST_X8: begin
        cmd.a_sel = A_ED; cmd.b_sel = B_KPD; cmd.qint_ld = 1'b1;
        state_nxt = ST_X9;
      end
      ST_X9: begin
        cmd.a_sel = A_EQ; cmd.b_sel = B_KPQ; cmd.vd_ld = 1'b1;
        state_nxt = ST_X10;
      end
      ST_X10: begin
        cmd.a_sel = A_VDH; cmd.b_sel = B_C; cmd.vq_ld = 1'b1;
        state_nxt = ST_X11;
      end
      ST_X11: begin
        cmd.a_sel = A_VDL; cmd.b_sel = B_C; cmd.acc_op = ACC_LOAD_HI;
        state_nxt = ST_X12;
      end
      ST_X12: begin
        cmd.a_sel = A_VQH; cmd.b_sel = B_S; cmd.acc_op = ACC_ADD;
        state_nxt = ST_X13;
      end
      ST_X13: begin
        cmd.a_sel = A_VQL; cmd.b_sel = B_S; cmd.acc_op = ACC_SUB_HI;
        state_nxt = ST_X14;
      end
      ST_X14: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.duty_ld   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RCC: begin
        cmd.a_sel = A_CCL; cmd.b_sel = B_CCL;
        state_nxt = ST_RV;
      end
      ST_RV: begin
        cmd.sq_init = 1'b1;
        state_nxt   = ST_RSM;
      end
      ST_RSM: begin
        cmd.a_sel = A_TRIAL; cmd.b_sel = B_TRIAL;
        state_nxt = ST_RSC;
      end
      ST_RSC: begin
        cmd.sq_cmp = 1'b1;
        state_nxt  = sq_last ? ST_RD : ST_RSM;
      end
      ST_RD: begin
        cmd.a_sel = A_AMP; cmd.b_sel = B_CCL;
        state_nxt = ST_RQ;
      end
      ST_RQ: begin
        cmd.a_sel = A_AMP; cmd.b_sel = B_ROOT; cmd.dref_ld = 1'b1;
        state_nxt = ST_RF;
      end
      ST_RF: begin
        cmd.qref_ld = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SPDQ_ASSERT_NEXT(a_accept_fetch, in_valid && in_ready, state_r == ST_FETCH)
  `SPDQ_ASSERT_NEXT(a_ref_start, cfg_valid && cfg_ready && ref_write, state_r == ST_RCC)
  `SPDQ_ASSERT_NEXT(a_out_hold, state_r == ST_OUT && out_valid_r && !out_ready,
                    state_r == ST_OUT && out_valid_r)
  `SPDQ_ASSERT_NEXT(a_root_done, state_r == ST_RSC && sq_last, state_r == ST_RD)
  `SPDQ_ASSERT_NOW(a_busy_closed, state_r != ST_IDLE, !in_ready && !cfg_ready)

endmodule

// ----- sv/spdq_dp.sv -----
// ----------------------------------------------------------------------------
// spdq_dp
// Datapath: delay line, shared multiplier, accumulator, PI state, references.
// ----------------------------------------------------------------------------
module spdq_dp
  import spdq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmd_t                           cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_current_sample,
  input  logic [15:0]                    in_phase,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  output logic [15:0]                    out_duty,
  output logic                           sq_last
);

  localparam int PW1 = P_W + 1;

  logic [1:0]  lt_r;
  logic [15:0] pf_r;
  logic [14:0] amp_r;
  logic [15:0] kpd_r, kid_r, kpq_r, kiq_r;

  logic signed [SAMPLE_WIDTH-1:0] ia_r, ib_r;
  logic [15:0]                    ph_r;
  logic [IDX_W-1:0]               idx_r;
  logic                           wrapped_r;
  logic [SAMPLE_WIDTH-1:0]        ram_rdata;

  logic signed [SIN_W-1:0] s_r, c_r;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   p_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_rnd15, duty_sum;
  logic signed [PW1-1:0]   p_rnd15;

  logic signed [ID_W-1:0]  id_r;
  logic signed [ERR_W-1:0] ed_r, eq_r;
  logic signed [INT_W-1:0] dint_r, qint_r;
  logic signed [V_W-1:0]   vd_r, vq_r;
  logic signed [REF_W-1:0] dref_r, qref_r;
  logic [15:0]             duty_r;

  logic [15:0]        ccl;
  logic [30:0]        v_r;
  logic [ROOT_W-1:0]  res_r, trial;
  logic [3:0]         k_r;

  function automatic logic signed [INT_W-1:0] integ_step(
    input logic signed [INT_W-1:0] cur,
    input logic signed [P_W-1:0]   prod
  );
    logic signed [PW1-1:0] inc;
    logic signed [PW1-1:0] sum;
    inc = (PW1'(prod) + PW1'(128)) >>> 8;
    sum = PW1'(cur) + inc;
    if (sum > PW1'(INTEG_LIM)) begin
      integ_step = INT_W'(INTEG_LIM);
    end else if (sum < -PW1'(INTEG_LIM)) begin
      integ_step = -INT_W'(INTEG_LIM);
    end else begin
      integ_step = INT_W'(sum);
    end
  endfunction

  spdq_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk   (clk),
    .we    (cmd.fetch),
    .waddr (idx_r),
    .wdata (ia_r),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign ccl = (pf_r < 16'(COSPHI_LO)) ? 16'(COSPHI_LO) :
               (pf_r > 16'(COSPHI_HI)) ? 16'(COSPHI_HI) : pf_r;
  assign trial   = res_r | (ROOT_W'(1) << k_r);
  assign sq_last = (k_r == 4'd0);

  always_comb begin
    case (cmd.a_sel)
      A_IA:    mul_a = MA_W'(ia_r);
      A_IB:    mul_a = MA_W'(ib_r);
      A_ED:    mul_a = MA_W'(ed_r);
      A_EQ:    mul_a = MA_W'(eq_r);
      A_VDH:   mul_a = MA_W'(signed'(vd_r[V_W-1:HI_SH]));
      A_VDL:   mul_a = MA_W'({1'b0, vd_r[HI_SH-1:0]});
      A_VQH:   mul_a = MA_W'(signed'(vq_r[V_W-1:HI_SH]));
      A_VQL:   mul_a = MA_W'({1'b0, vq_r[HI_SH-1:0]});
      A_CCL:   mul_a = MA_W'(ccl);
      A_TRIAL: mul_a = MA_W'(trial);
      A_AMP:   mul_a = MA_W'(amp_r);
      default: mul_a = '0;
    endcase
    case (cmd.b_sel)
      B_C:     mul_b = c_r;
      B_S:     mul_b = s_r;
      B_KID:   mul_b = {1'b0, kid_r};
      B_KIQ:   mul_b = {1'b0, kiq_r};
      B_KPD:   mul_b = {1'b0, kpd_r};
      B_KPQ:   mul_b = {1'b0, kpq_r};
      B_CCL:   mul_b = {1'b0, ccl};
      B_TRIAL: mul_b = MB_W'(trial);
      B_ROOT:  mul_b = MB_W'(res_r);
      default: mul_b = '0;
    endcase
    case (cmd.acc_op)
      ACC_LOAD:    acc_nxt = ACC_W'(p_r);
      ACC_ADD:     acc_nxt = acc_r + ACC_W'(p_r);
      ACC_SUB:     acc_nxt = acc_r - ACC_W'(p_r);
      ACC_LOAD_HI: acc_nxt = ACC_W'(p_r) <<< HI_SH;
      ACC_SUB_HI:  acc_nxt = acc_r - (ACC_W'(p_r) <<< HI_SH);
      default:     acc_nxt = acc_r;
    endcase
  end

  assign acc_rnd15 = (acc_r + ACC_W'(16384)) >>> 15;
  assign p_rnd15   = (PW1'(p_r) + PW1'(16384)) >>> 15;
  assign duty_sum  = ((acc_r + ACC_W'(524288)) >>> 20) + ACC_W'(32768);
  assign out_duty  = duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r      <= '0;
      pf_r      <= 16'd32768;
      amp_r     <= 15'd4096;
      kpd_r     <= 16'd256;
      kid_r     <= 16'd256;
      kpq_r     <= 16'd256;
      kiq_r     <= 16'd256;
      idx_r     <= '0;
      wrapped_r <= 1'b0;
      dint_r    <= '0;
      qint_r    <= '0;
      dref_r    <= REF_W'(4096);
      qref_r    <= '0;
    end else begin
      if (cmd.cfg_we) begin
        unique case (cfg_index)
          REG_LOAD_TYPE:    lt_r  <= cfg_data[1:0];
          REG_POWER_FACTOR: pf_r  <= cfg_data;
          REG_CURRENT_AMP:  amp_r <= cfg_data[14:0];
          REG_D_PROP_GAIN:  kpd_r <= cfg_data;
          REG_D_INTEG_GAIN: kid_r <= cfg_data;
          REG_Q_PROP_GAIN:  kpq_r <= cfg_data;
          REG_Q_INTEG_GAIN: kiq_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.fetch) begin
        if (idx_r == IDX_W'(DELAY_DEPTH - 1)) begin
          idx_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (cmd.dint_ld) dint_r <= integ_step(dint_r, p_r);
      if (cmd.qint_ld) qint_r <= integ_step(qint_r, p_r);
      if (cmd.dref_ld) dref_r <= REF_W'(p_rnd15);
      if (cmd.qref_ld) begin
        if (lt_r == LOAD_INDUCTIVE) begin
          qref_r <= -REF_W'(p_rnd15);
        end else if (lt_r == LOAD_CAPACITIVE) begin
          qref_r <= REF_W'(p_rnd15);
        end else begin
          qref_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= mul_a * mul_b;
    acc_r <= acc_nxt;
    if (cmd.capture) begin
      ia_r <= in_current_sample;
      ph_r <= in_phase;
    end
    if (cmd.fetch) begin
      ib_r <= wrapped_r ? signed'(ram_rdata) : '0;
      s_r  <= sin_q15(ph_r);
    end
    if (cmd.cos_ld) c_r <= sin_q15(16'(ph_r + 16'd16384));
    if (cmd.id_ld)  id_r <= ID_W'(acc_rnd15);
    if (cmd.ed_ld)  ed_r <= ERR_W'(dref_r) - ERR_W'(id_r);
    if (cmd.eq_ld)  eq_r <= ERR_W'(qref_r) - ERR_W'(ID_W'(acc_rnd15));
    if (cmd.vd_ld)  vd_r <= V_W'(PW1'(p_r) + PW1'(dint_r));
    if (cmd.vq_ld)  vq_r <= V_W'(PW1'(p_r) + PW1'(qint_r));
    if (cmd.duty_ld) begin
      if (duty_sum < ACC_W'(DUTY_LO)) begin
        duty_r <= 16'(DUTY_LO);
      end else if (duty_sum > ACC_W'(DUTY_HI)) begin
        duty_r <= 16'(DUTY_HI);
      end else begin
        duty_r <= duty_sum[15:0];
      end
    end
    if (cmd.sq_init) begin
      v_r   <= 31'(31'h4000_0000 - p_r[30:0]);
      res_r <= '0;
      k_r   <= 4'(ROOT_W - 1);
    end
    if (cmd.sq_cmp) begin
      if (p_r[30:0] <= v_r) res_r <= trial;
      k_r <= k_r - 4'd1;
    end
  end

endmodule

// ----- sv/single_phase_dq_current_regulator.sv -----
// Sequencing: a new sample is accepted only once the previous one is finished,
//   set by the step sequencer sharing a single multiplier and accumulator.
// A write to load_type, power_factor or current_amp holds both ports while the
//   references are recomputed (bit-serial square root).
// Reset: synchronous, active low; delay line entries read as zero until first
//   written (wrap flag), no clearing pass.
// ----------------------------------------------------------------------------
// single_phase_dq_current_regulator
// Single-phase dq PI current regulator producing a clamped PWM duty.
// ----------------------------------------------------------------------------
module single_phase_dq_current_regulator
  import spdq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_current_sample,
  input  logic [15:0]                    in_phase,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_duty,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  cmd_t cmd;
  logic sq_last;

  spdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sq_last   (sq_last),
    .cmd       (cmd)
  );

  spdq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_current_sample (in_current_sample),
    .in_phase          (in_phase),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_duty          (out_duty),
    .sq_last           (sq_last)
  );

endmodule
